FILE: hw/rtl/fmwa_pkg.sv
`default_nettype none
package fmwa_pkg;

   // set count and field widths
   localparam int NUM_SETS          = 5;
   localparam int BP_BITS           = 10;
   localparam int LVL_BITS          = 8;
   localparam int LEVELS_BITS       = NUM_SETS * LVL_BITS;
   localparam int AMOUNT_BITS       = 16;
   localparam int FRAC_BITS         = 8;
   localparam int PROD_BITS         = LVL_BITS + BP_BITS;
   localparam int NUM_BITS          = PROD_BITS + FRAC_BITS;
   localparam int QUO_BITS          = AMOUNT_BITS;
   localparam int MOISTURE_BITS_DEF = 10;

   // configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = LEVELS_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEVELS = 3'd5;

   // reset values
   localparam logic [BP_BITS-1:0] BP_RESET [NUM_SETS] =
      '{10'd300, 10'd400, 10'd500, 10'd600, 10'd700};
   localparam logic [LEVELS_BITS-1:0] LEVELS_RESET = 40'h02_06_04_08_0A;

   // classify stage payload
   typedef struct packed {
      logic                   bad;
      logic                   exact;
      logic                   neg;
      logic [AMOUNT_BITS-1:0] base;
      logic [LVL_BITS-1:0]    diff;
      logic [BP_BITS-1:0]     dm;
      logic [BP_BITS-1:0]     den;
   } cls_type;

   // multiply stage payload
   typedef struct packed {
      logic                   bad;
      logic                   exact;
      logic                   neg;
      logic [AMOUNT_BITS-1:0] base;
      logic [BP_BITS-1:0]     den;
      logic [NUM_BITS-1:0]    num;
   } mul_type;

   // divider stage payload
   typedef struct packed {
      logic                   bad;
      logic                   exact;
      logic                   neg;
      logic [AMOUNT_BITS-1:0] base;
      logic [BP_BITS-1:0]     den;
      logic [NUM_BITS-1:0]    rem;
      logic [QUO_BITS-1:0]    quo;
   } div_type;

endpackage
`default_nettype wire

FILE: hw/rtl/fuzzy_moisture_to_water_amount_top.sv
`default_nettype none
// pipeline: a request passes through the classify stage, the multiply stage,
// sixteen restoring divider stages and the output register, in that order
// throughput: one request per cycle; each divider stage resolves one quotient bit
// stages hold their data under back-pressure and bubbles are squeezed out
// reset: synchronous, active high; clears all valid bits and reloads the
// breakpoints and water levels to their defaults
module fuzzy_moisture_to_water_amount_top #(
   parameter int MOISTURE_BITS = fmwa_pkg::MOISTURE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [MOISTURE_BITS-1:0]           req_moisture,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [fmwa_pkg::AMOUNT_BITS-1:0]        rsp_water_amount,
   output logic                                    rsp_exact_level,
   output logic                                    rsp_bad_config,
   input  wire logic                               csr_we,
   input  wire logic [fmwa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [fmwa_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import fmwa_pkg::*;

   localparam int CMP_W      = (MOISTURE_BITS > BP_BITS) ? MOISTURE_BITS : BP_BITS;
   localparam int DIV_STAGES = QUO_BITS;

   // configuration registers
   logic [BP_BITS-1:0]     bp_ff [NUM_SETS];
   logic [LEVELS_BITS-1:0] levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_SETS; k++) begin
            bp_ff[k] <= BP_RESET[k];
         end
         levels_ff <= LEVELS_RESET;
      end else if (csr_we) begin
         if (csr_index < CSR_LEVELS) begin
            bp_ff[csr_index] <= csr_wdata[BP_BITS-1:0];
         end else if (csr_index == CSR_LEVELS) begin
            levels_ff <= csr_wdata;
         end
      end
   end

   // pipeline valid bits and ready chain
   logic                  cls_vld_ff;
   logic                  mul_vld_ff;
   logic [DIV_STAGES-1:0] div_vld_ff;
   logic                  rsp_vld_ff;
   logic                  cls_rdy;
   logic                  mul_rdy;
   logic [DIV_STAGES-1:0] div_rdy;
   logic                  out_rdy;

   assign out_rdy = !rsp_vld_ff || rsp_ready;
   assign mul_rdy = !mul_vld_ff || div_rdy[0];
   assign cls_rdy = !cls_vld_ff || mul_rdy;
   assign req_ready = cls_rdy;

   always_comb begin
      div_rdy[DIV_STAGES-1] = !div_vld_ff[DIV_STAGES-1] || out_rdy;
      for (int j = DIV_STAGES - 2; j >= 0; j--) begin
         div_rdy[j] = !div_vld_ff[j] || div_rdy[j+1];
      end
   end

   // classify: config check, interval search, blend operands
   cls_type              cls_in;
   cls_type              cls_ff;
   logic [CMP_W-1:0]     mx;
   logic [CMP_W-1:0]     bpx [NUM_SETS];

   always_comb begin
      logic                bad;
      logic                found;
      logic [LVL_BITS-1:0] la;
      logic [LVL_BITS-1:0] lb;
      mx = CMP_W'(req_moisture);
      for (int k = 0; k < NUM_SETS; k++) begin
         bpx[k] = CMP_W'(bp_ff[k]);
      end
      bad = 1'b0;
      for (int k = 0; k < NUM_SETS - 1; k++) begin
         if (bp_ff[k] >= bp_ff[k+1]) begin
            bad = 1'b1;
         end
      end
      cls_in       = '0;
      cls_in.den   = BP_BITS'(1);
      found        = 1'b0;
      la           = '0;
      lb           = '0;
      if (bad) begin
         cls_in.bad = 1'b1;
      end else if (mx <= bpx[0]) begin
         cls_in.exact = 1'b1;
         cls_in.base  = {levels_ff[LVL_BITS-1:0], FRAC_BITS'(0)};
      end else if (mx >= bpx[NUM_SETS-1]) begin
         cls_in.exact = 1'b1;
         cls_in.base  = {levels_ff[LEVELS_BITS-1 -: LVL_BITS], FRAC_BITS'(0)};
      end else begin
         for (int k = 0; k < NUM_SETS - 1; k++) begin
            if (!found && mx >= bpx[k] && mx < bpx[k+1]) begin
               found       = 1'b1;
               la          = levels_ff[LVL_BITS*k +: LVL_BITS];
               lb          = levels_ff[LVL_BITS*(k+1) +: LVL_BITS];
               cls_in.base = {la, FRAC_BITS'(0)};
               if (mx == bpx[k]) begin
                  cls_in.exact = 1'b1;
               end else begin
                  cls_in.neg  = lb < la;
                  cls_in.diff = (lb < la) ? la - lb : lb - la;
                  cls_in.dm   = BP_BITS'(mx - bpx[k]);
                  cls_in.den  = bp_ff[k+1] - bp_ff[k];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_vld_ff <= 1'b0;
      end else if (cls_rdy) begin
         cls_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cls_rdy && req_valid) begin
         cls_ff <= cls_in;
      end
   end

   // multiply: level gap times distance, scaled to 1/256
   mul_type              mul_in;
   mul_type              mul_ff;
   logic [PROD_BITS-1:0] prod;

   always_comb begin
      prod         = PROD_BITS'(cls_ff.diff) * PROD_BITS'(cls_ff.dm);
      mul_in.bad   = cls_ff.bad;
      mul_in.exact = cls_ff.exact;
      mul_in.neg   = cls_ff.neg;
      mul_in.base  = cls_ff.base;
      mul_in.den   = cls_ff.den;
      mul_in.num   = {prod, FRAC_BITS'(0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (mul_rdy) begin
         mul_vld_ff <= cls_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_rdy && cls_vld_ff) begin
         mul_ff <= mul_in;
      end
   end

   // restoring divider, one quotient bit per stage, msb first
   div_type div_src [DIV_STAGES];
   div_type div_in  [DIV_STAGES];
   div_type div_ff  [DIV_STAGES];
   logic    div_src_vld [DIV_STAGES];

   always_comb begin
      div_src[0].bad   = mul_ff.bad;
      div_src[0].exact = mul_ff.exact;
      div_src[0].neg   = mul_ff.neg;
      div_src[0].base  = mul_ff.base;
      div_src[0].den   = mul_ff.den;
      div_src[0].rem   = mul_ff.num;
      div_src[0].quo   = '0;
      div_src_vld[0]   = mul_vld_ff;
      for (int j = 1; j < DIV_STAGES; j++) begin
         div_src[j]     = div_ff[j-1];
         div_src_vld[j] = div_vld_ff[j-1];
      end
   end

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      localparam int SH = DIV_STAGES - 1 - j;
      logic [NUM_BITS:0] trial;

      always_comb begin
         trial     = {1'b0, div_src[j].rem} - {1'b0, NUM_BITS'(div_src[j].den) << SH};
         div_in[j] = div_src[j];
         if (!trial[NUM_BITS]) begin
            div_in[j].rem     = trial[NUM_BITS-1:0];
            div_in[j].quo[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[j] <= 1'b0;
         end else if (div_rdy[j]) begin
            div_vld_ff[j] <= div_src_vld[j];
         end
      end

      always_ff @(posedge clock) begin
         if (div_rdy[j] && div_src_vld[j]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // output register: apply signed quotient to base level, zero on bad config
   div_type                last_div;
   logic [AMOUNT_BITS-1:0] amount_in;
   logic [AMOUNT_BITS-1:0] amount_ff;
   logic                   exact_ff;
   logic                   bad_ff;

   assign last_div = div_ff[DIV_STAGES-1];

   always_comb begin
      if (last_div.bad) begin
         amount_in = '0;
      end else if (last_div.neg) begin
         amount_in = last_div.base - last_div.quo;
      end else begin
         amount_in = last_div.base + last_div.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_vld_ff <= div_vld_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && div_vld_ff[DIV_STAGES-1]) begin
         amount_ff <= amount_in;
         exact_ff  <= last_div.exact;
         bad_ff    <= last_div.bad;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_water_amount = amount_ff;
   assign rsp_exact_level  = exact_ff;
   assign rsp_bad_config   = bad_ff;

   // checks on internal consistency
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && bad_ff |-> amount_ff == '0 && !exact_ff)
      else $error("bad config response carries nonzero amount or exact flag");

   a_no_blend_num: assert property (@(posedge clock) disable iff (reset)
      mul_vld_ff && (mul_ff.bad || mul_ff.exact) |-> mul_ff.num == '0)
      else $error("exact or bad request has nonzero numerator");

   a_dist_in_range: assert property (@(posedge clock) disable iff (reset)
      cls_vld_ff && !cls_ff.bad && !cls_ff.exact |-> cls_ff.dm < cls_ff.den)
      else $error("blend distance not below interval width");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      div_vld_ff[DIV_STAGES-1] |-> last_div.rem < NUM_BITS'(last_div.den))
      else $error("divider remainder not below divisor");

   a_out_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ready |=> rsp_vld_ff && $stable(amount_ff))
      else $error("output register changed while stalled");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MB            = fmwa_pkg::MOISTURE_BITS_DEF;
   localparam int MOISTURE_MAX  = (1 << MB) - 1;
   localparam int NUM_PHASES    = 14;
   localparam int PHASE_SAMPLES = 118;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 20;

   // register map: breakpoints at consecutive indexes, indexes 6 and 7 left unused
   localparam logic [fmwa_pkg::CSR_IDX_BITS-1:0] CSR_BP0    = 3'd0;
   localparam logic [fmwa_pkg::CSR_IDX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [fmwa_pkg::AMOUNT_BITS-1:0] amount;
      logic                             exact;
      logic                             bad;
   } water_result_type;

   // predicts the watering amount and holds the responses still due
   class water_scoreboard;
      logic [fmwa_pkg::BP_BITS-1:0]     bp [fmwa_pkg::NUM_SETS];
      logic [fmwa_pkg::LEVELS_BITS-1:0] levels;
      water_result_type                 pending [$];
      int errors;
      int n_checked;
      int n_exact;
      int n_blend;
      int n_bad;

      function new();
         bp = '{10'd300, 10'd400, 10'd500, 10'd600, 10'd700};
         levels    = {8'd2, 8'd6, 8'd4, 8'd8, 8'd10};
         errors    = 0;
         n_checked = 0;
         n_exact   = 0;
         n_blend   = 0;
         n_bad     = 0;
      endfunction

      function void apply_write(logic [fmwa_pkg::CSR_IDX_BITS-1:0] idx,
                                logic [fmwa_pkg::CSR_DATA_BITS-1:0] data);
         if (idx < fmwa_pkg::NUM_SETS)
            bp[idx] = data[fmwa_pkg::BP_BITS-1:0];
         else if (idx == fmwa_pkg::CSR_LEVELS)
            levels = data;
      endfunction

      function longint level_of(int k);
         return longint'(levels[8*k +: 8]);
      endfunction

      function water_result_type predict_water(logic [MB-1:0] m);
         water_result_type r;
         longint lo, hi, a, b, mm, v;
         r = '0;
         // breakpoints must rise strictly, otherwise flag and give nothing
         for (int k = 0; k + 1 < fmwa_pkg::NUM_SETS; k++) begin
            if (bp[k] >= bp[k+1]) begin
               r.bad = 1'b1;
               return r;
            end
         end
         mm = longint'(m);
         if (mm <= longint'(bp[0])) begin
            r.amount = 16'(level_of(0) * 256);
            r.exact  = 1'b1;
         end else if (mm >= longint'(bp[4])) begin
            r.amount = 16'(level_of(4) * 256);
            r.exact  = 1'b1;
         end else begin
            for (int k = 0; k + 1 < fmwa_pkg::NUM_SETS; k++) begin
               lo = longint'(bp[k]);
               hi = longint'(bp[k+1]);
               if (mm == lo) begin
                  r.amount = 16'(level_of(k) * 256);
                  r.exact  = 1'b1;
                  break;
               end
               // linear blend, quotient truncates toward zero
               if (mm > lo && mm < hi) begin
                  a = level_of(k);
                  b = level_of(k + 1);
                  v = a * 256 + ((b - a) * 256 * (mm - lo)) / (hi - lo);
                  r.amount = 16'(v);
                  break;
               end
            end
         end
         return r;
      endfunction

      function void note_request(logic [MB-1:0] m);
         water_result_type r;
         r = predict_water(m);
         if (r.bad)
            n_bad++;
         else if (r.exact)
            n_exact++;
         else
            n_blend++;
         pending.push_back(r);
      endfunction

      function void check_response(logic [fmwa_pkg::AMOUNT_BITS-1:0] amount,
                                   logic exact, logic bad);
         water_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected response: water_amount %0d", amount);
            errors++;
            return;
         end
         e = pending.pop_front();
         n_checked++;
         if (amount !== e.amount) begin
            $error("water_amount: expected %0d, actual %0d", e.amount, amount);
            errors++;
         end
         if (exact !== e.exact) begin
            $error("exact_level: expected %0d, actual %0d", e.exact, exact);
            errors++;
         end
         if (bad !== e.bad) begin
            $error("bad_config: expected %0d, actual %0d", e.bad, bad);
            errors++;
         end
      endfunction
   endclass

   logic                               clock        = 1'b0;
   logic                               reset        = 1'b1;
   logic                               req_valid    = 1'b0;
   logic                               req_ready;
   logic [MB-1:0]                      req_moisture = '0;
   logic                               rsp_valid;
   logic                               rsp_ready    = 1'b0;
   logic [fmwa_pkg::AMOUNT_BITS-1:0]   rsp_water_amount;
   logic                               rsp_exact_level;
   logic                               rsp_bad_config;
   logic                               csr_we       = 1'b0;
   logic [fmwa_pkg::CSR_IDX_BITS-1:0]  csr_index    = '0;
   logic [fmwa_pkg::CSR_DATA_BITS-1:0] csr_wdata    = '0;

   water_scoreboard sb = new();
   int gap_pct   = 0;
   int stall_pct = 0;
   int directed_samples [24] = '{0, 1023, 1000, 300, 400, 500, 600, 700, 299, 301,
                                 399, 401, 499, 501, 599, 601, 699, 701, 350, 450,
                                 550, 650, 341, 682};

   fuzzy_moisture_to_water_amount_top #(.MOISTURE_BITS(MB)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_moisture     (req_moisture),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_water_amount (rsp_water_amount),
      .rsp_exact_level  (rsp_exact_level),
      .rsp_bad_config   (rsp_bad_config),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side: check on handshake, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_water_amount, rsp_exact_level, rsp_bad_config);
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_moisture(input logic [MB-1:0] m);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_moisture <= m;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_request(m);
   endtask

   task automatic write_register(input logic [fmwa_pkg::CSR_IDX_BITS-1:0] idx,
                                 input logic [fmwa_pkg::CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.apply_write(idx, data);
   endtask

   // wait for every outstanding request to come back, then let the pipe settle
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $error("%0d responses never arrived", sb.pending.size());
         sb.errors++;
         sb.pending.delete();
      end
   endtask

   // 35% on or next to a breakpoint, 10% at 0, 1000 or the maximum, the rest uniform
   function automatic logic [MB-1:0] pick_moisture();
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 35)
         v = int'(sb.bp[$urandom_range(4)]) + int'($urandom_range(4)) - 2;
      else if (r < 45)
         v = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 1000 : MOISTURE_MAX);
      else
         v = $urandom_range(MOISTURE_MAX);
      if (v < 0)
         v = 0;
      if (v > MOISTURE_MAX)
         v = MOISTURE_MAX;
      return v[MB-1:0];
   endfunction

   initial begin
      int bp_new [fmwa_pkg::NUM_SETS];
      logic [fmwa_pkg::CSR_DATA_BITS-1:0] lv_new;
      logic [fmwa_pkg::CSR_DATA_BITS-1:0] data;
      int j;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed samples against the default breakpoints and levels
      foreach (directed_samples[i])
         send_moisture(directed_samples[i][MB-1:0]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();

         // pick the next register setting
         case (p)
            0: begin
               bp_new = '{300, 400, 500, 600, 700};
               lv_new = 40'h02_06_04_08_0A;
            end
            1: begin
               bp_new = '{0, 1, 2, 3, 4};
               lv_new = 40'hFF_00_FF_00_FF;
            end
            2: begin
               bp_new = '{1019, 1020, 1021, 1022, 1023};
               lv_new = 40'h00_FF_00_FF_00;
            end
            3: begin
               bp_new = '{0, 255, 511, 767, 1023};
               lv_new = 40'hFF_FF_FF_FF_FF;
            end
            4: begin
               bp_new = '{0, 1, 512, 1022, 1023};
               lv_new = '0;
            end
            6: begin
               // falling breakpoints, neighbors may also tie
               bp_new[0] = $urandom_range(1023, 800);
               for (int k = 1; k < fmwa_pkg::NUM_SETS; k++)
                  bp_new[k] = bp_new[k-1] - int'($urandom_range(150));
               lv_new = 40'({$urandom(), $urandom()});
            end
            default: begin
               bp_new[0] = $urandom_range(300);
               for (int k = 1; k < fmwa_pkg::NUM_SETS; k++)
                  bp_new[k] = bp_new[k-1] + int'(($urandom_range(2) == 0) ?
                              $urandom_range(4, 1) : $urandom_range(180, 1));
               lv_new = 40'({$urandom(), $urandom()});
               // two equal neighbors make a bad setting
               if (p == 5 || p == 9) begin
                  j = $urandom_range(3);
                  bp_new[j+1] = bp_new[j];
               end
            end
         endcase

         // program all registers, junk in the unused upper data bits
         for (int k = 0; k < fmwa_pkg::NUM_SETS; k++) begin
            data = 40'({$urandom(), $urandom()});
            data[fmwa_pkg::BP_BITS-1:0] = bp_new[k][fmwa_pkg::BP_BITS-1:0];
            write_register(CSR_BP0 + 3'(k), data);
         end
         if (p == 0)
            write_register(CSR_UNUSED, 40'({$urandom(), $urandom()}));
         write_register(fmwa_pkg::CSR_LEVELS, lv_new);
         csr_we <= 1'b0;

         // idling mode for this phase
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 75; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 75; end
            default: begin gap_pct = 17; stall_pct = 17; end
         endcase

         for (int i = 0; i < PHASE_SAMPLES; i++)
            send_moisture(pick_moisture());
      end

      drain();
      $display("tb: %0d responses checked over %0d register settings plus defaults",
               sb.n_checked, NUM_PHASES);
      $display("tb: %0d exact level, %0d blended, %0d with bad breakpoints",
               sb.n_exact, sb.n_blend, sb.n_bad);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/fmwa_pkg.sv
hw/rtl/fuzzy_moisture_to_water_amount_top.sv
verif/tb_top.sv
